### rtl/assert_macros.svh
// Assertion macros used by the top level of the half-band decimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ihbd_pkg.sv
// Package with the types and constants of the half-band decimator.
`timescale 1ns / 1ps
package ihbd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W = SAMPLE_W + 1;
	localparam int ACC_W = 32;
	localparam int DELAY_DEPTH = 32;

	// The oldest tap sits at delay 29, so the cells hold delays 0 to 28 before a shift.
	localparam int TAP_CELLS = DELAY_DEPTH - 3;
	localparam int NEAR_TAP = 6;
	localparam int CENTER_TAP = 17;
	localparam int NUM_PAIRS = 6;

	localparam int CENTER_SHIFT = 14;
	localparam int OUT_SHIFT = 15;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	localparam logic signed [SAMPLE_W-1:0] COEF [NUM_PAIRS] = '{
		-16'sd22, 16'sd125, -16'sd420, 16'sd1121, -16'sd2795, 16'sd10183
	};

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t i;
		sample_t q;
	} iq_t;

endpackage

### rtl/ihbd_in_if.sv
// Stream interface that carries one I/Q input pair per transfer.
`timescale 1ns / 1ps
interface ihbd_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] i_in;
	logic signed [15:0] q_in;

	modport source (output valid, output i_in, output q_in, input ready);
	modport sink (input valid, input i_in, input q_in, output ready);
endinterface

### rtl/ihbd_out_if.sv
// Stream interface that carries one filtered I/Q output pair per transfer.
`timescale 1ns / 1ps
interface ihbd_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] i_out;
	logic signed [15:0] q_out;

	modport source (output valid, output i_out, output q_out, input ready);
	modport sink (input valid, input i_out, input q_out, output ready);
endinterface

### rtl/ihbd_cell.sv
// One delay cell of the sample chain: holds one I/Q pair and hands it on.
`timescale 1ns / 1ps
module ihbd_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ihbd_pkg::iq_t d,
	output ihbd_pkg::iq_t q
);

	ihbd_pkg::iq_t data_q;

	// The delay line starts out as zeros, so early outputs see silence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

### rtl/ihbd_fir.sv
// Five-stage pipelined symmetric half-band filter for one channel.
`timescale 1ns / 1ps
module ihbd_fir (
	input  logic             clk,
	input  logic             en,
	input  ihbd_pkg::sample_t taps [ihbd_pkg::TAP_CELLS],
	output ihbd_pkg::sample_t y
);

	logic signed [ihbd_pkg::SUM_W-1:0] pre_s1 [ihbd_pkg::NUM_PAIRS];
	ihbd_pkg::sample_t                 center_s1;
	logic signed [ihbd_pkg::ACC_W-1:0] prod_s2 [ihbd_pkg::NUM_PAIRS];
	logic signed [ihbd_pkg::ACC_W-1:0] center_s2;
	logic signed [ihbd_pkg::ACC_W-1:0] sum01_s3, sum23_s3, sum45_s3, center_s3;
	logic signed [ihbd_pkg::ACC_W-1:0] lo_s4, hi_s4;
	ihbd_pkg::sample_t                 y_s5;
	logic signed [ihbd_pkg::ACC_W-1:0] total;
	logic signed [ihbd_pkg::ACC_W-ihbd_pkg::OUT_SHIFT-1:0] shifted;

	// Stage 1 folds the symmetric taps; stage 2 scales them by the coefficients.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ihbd_pkg::NUM_PAIRS; k++) begin
				pre_s1[k] <= ihbd_pkg::SUM_W'(taps[ihbd_pkg::TAP_CELLS-1-2*k])
					+ ihbd_pkg::SUM_W'(taps[ihbd_pkg::NEAR_TAP+2*k]);
				prod_s2[k] <= ihbd_pkg::ACC_W'(pre_s1[k])
					* ihbd_pkg::ACC_W'(ihbd_pkg::COEF[k]);
			end
			center_s1 <= taps[ihbd_pkg::CENTER_TAP];
			center_s2 <= ihbd_pkg::ACC_W'(center_s1) <<< ihbd_pkg::CENTER_SHIFT;
			sum01_s3  <= prod_s2[0] + prod_s2[1];
			sum23_s3  <= prod_s2[2] + prod_s2[3];
			sum45_s3  <= prod_s2[4] + prod_s2[5];
			center_s3 <= center_s2;
			lo_s4     <= sum01_s3 + sum23_s3;
			hi_s4     <= sum45_s3 + center_s3;
			y_s5      <= (shifted[ihbd_pkg::ACC_W-ihbd_pkg::OUT_SHIFT-1]
				!= shifted[ihbd_pkg::SAMPLE_W-1])
				? (shifted[ihbd_pkg::ACC_W-ihbd_pkg::OUT_SHIFT-1]
					? ihbd_pkg::SAMPLE_MIN : ihbd_pkg::SAMPLE_MAX)
				: shifted[ihbd_pkg::SAMPLE_W-1:0];
		end
	end

	// Dropping the low bits of the sum is an arithmetic shift, rounding down.
	assign total   = lo_s4 + hi_s4;
	assign shifted = total[ihbd_pkg::ACC_W-1:ihbd_pkg::OUT_SHIFT];
	assign y       = y_s5;

endmodule

### rtl/iq_half_band_decimator.sv
// Top level of the complex half-band decimator by two.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one I/Q sample pair per transfer on samples and gives one
// filtered pair on result for every second input pair: the first, third, fifth
// and so on after reset. Each part is run through a symmetric 23-tap half-band
// filter with fixed Q15 coefficients over the samples delayed 7 to 29, summed
// exactly, shifted right by 15 (rounding toward minus infinity) and saturated
// to 16 bits. The delay line is a chain of cells reset to zero, so samples
// before the first input count as zeros. One input pair is taken every cycle
// while no result is stalled; a result is offered on result once the input
// pair that causes it has reached the last of the five register stages of
// the filter pipeline, the first of which loads at the input transfer edge
// itself. When a result waits in the output register and is not taken, the
// whole pipeline and the input hold until it is; otherwise the input stays
// ready.
module iq_half_band_decimator (
	input  logic      clk,
	input  logic      arst_n,
	ihbd_in_if.sink   samples,
	ihbd_out_if.source result
);

	logic              advance;
	logic              accept;
	logic              emit;
	logic              phase_q;
	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	ihbd_pkg::iq_t     chain_d [ihbd_pkg::TAP_CELLS];
	ihbd_pkg::iq_t     chain_q [ihbd_pkg::TAP_CELLS];
	ihbd_pkg::sample_t i_taps [ihbd_pkg::TAP_CELLS];
	ihbd_pkg::sample_t q_taps [ihbd_pkg::TAP_CELLS];
	ihbd_pkg::sample_t i_y, q_y;

	// The pipeline moves as one whenever the output register is free or being taken.
	assign advance       = !valid_s5 || result.ready;
	assign samples.ready = advance;
	assign accept        = samples.valid && advance;

	// Odd-numbered inputs produce a result, so a clear phase marks the next emitter.
	assign emit = accept && !phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= !phase_q;
			end
			if (advance) begin
				valid_s1 <= emit;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
				valid_s5 <= valid_s4;
			end
		end
	end

	// Chain of delay cells. Taps are read before the shift, so the cell at
	// position n supplies the sample that will sit at delay n + 1 afterward.
	genvar n;
	generate
		for (n = 0; n < ihbd_pkg::TAP_CELLS; n++) begin : g_chain
			if (n == 0) begin : g_head
				assign chain_d[n] = '{i: samples.i_in, q: samples.q_in};
			end else begin : g_link
				assign chain_d[n] = chain_q[n-1];
			end

			ihbd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (accept),
				.d      (chain_d[n]),
				.q      (chain_q[n])
			);

			assign i_taps[n] = chain_q[n].i;
			assign q_taps[n] = chain_q[n].q;
		end
	endgenerate

	ihbd_fir u_fir_i (
		.clk  (clk),
		.en   (advance),
		.taps (i_taps),
		.y    (i_y)
	);

	ihbd_fir u_fir_q (
		.clk  (clk),
		.en   (advance),
		.taps (q_taps),
		.y    (q_y)
	);

	assign result.valid = valid_s5;
	assign result.i_out = i_y;
	assign result.q_out = q_y;

	// An input that opens a pair starts a result down the pipeline.
	`ASSERT_NEXT(a_emit_starts, accept && !phase_q, valid_s1, "emitting input did not start a result")
	// The input that closes a pair never starts a result.
	`ASSERT_NEXT(a_pair_quiet, accept && phase_q, !valid_s1, "closing input started a result")
	// A stall freezes the stages in flight.
	`ASSERT_NEXT(a_stall_holds, !advance, valid_s3 == $past(valid_s3) && valid_s4 == $past(valid_s4), "pipeline moved during stall")
	// Results are at least two stages apart, so at most three are in flight.
	`ASSERT_ALWAYS(a_spacing, $countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5}) <= 3, "results crowded in pipeline")

endmodule
